FILE: rtl/lbsw_pkg.sv
// package for the bitmap serial writer
// holds display constants, register indexes and the job record passed front to back
`timescale 1ns / 1ps

package lbsw_pkg;

   localparam int DISPLAY_COLUMNS = 84;
   localparam int DISPLAY_BANKS   = 6;

   localparam logic [7:0] ROW_CMD = 8'h40;
   localparam logic [7:0] COL_CMD = 8'h80;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_COLUMN  = 2'd0,
      CSR_START_BANK    = 2'd1,
      CSR_WIDTH_PIXELS  = 2'd2,
      CSR_HEIGHT_PIXELS = 2'd3
   } csr_index_type;

   // one queued job: optional row/column command pair, then the pixel byte
   typedef struct packed {
      logic       header;
      logic [7:0] row_cmd;
      logic [7:0] col_cmd;
      logic [7:0] pixel;
   } job_type;

endpackage

FILE: rtl/lbsw_front.sv
// front end: config registers, band/column counters, classifies each beat
// and builds a job for the serializer; depends on lbsw_pkg
`timescale 1ns / 1ps

module lbsw_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_first,
   input  logic [7:0]                      req_pixel_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lbsw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbsw_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            queue_full,
   output logic                            push,
   output lbsw_pkg::job_type               push_job
);
   import lbsw_pkg::*;

   logic [6:0] start_column_ff;
   logic [2:0] start_bank_ff;
   logic [6:0] width_pixels_ff;
   logic [5:0] height_pixels_ff;

   logic [6:0] column_count_ff, column_count_in;
   logic [2:0] band_count_ff, band_count_in;
   logic       finished_ff, finished_in;

   logic       accept;
   logic [6:0] eff_col;
   logic [2:0] eff_band;
   logic       eff_fin;
   logic       empty_map;
   logic [3:0] bands;
   logic [2:0] row_addr;

   assign req_ready = !queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff  <= '0;
         start_bank_ff    <= '0;
         width_pixels_ff  <= 7'(DISPLAY_COLUMNS);
         height_pixels_ff <= 6'(8 * DISPLAY_BANKS);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_COLUMN:  start_column_ff  <= csr_data[6:0];
            CSR_START_BANK:    start_bank_ff    <= csr_data[2:0];
            CSR_WIDTH_PIXELS:  width_pixels_ff  <= csr_data[6:0];
            CSR_HEIGHT_PIXELS: height_pixels_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_col   = req_first ? '0 : column_count_ff;
      eff_band  = req_first ? '0 : band_count_ff;
      eff_fin   = req_first ? 1'b0 : finished_ff;
      empty_map = (width_pixels_ff == '0) || (height_pixels_ff == '0);
      // bands = ceil(height / 8), 0..8, 0 only for an empty bitmap
      bands     = 4'(({1'b0, height_pixels_ff} + 7'd7) >> 3);
      row_addr  = start_bank_ff + eff_band;

      push              = accept && !eff_fin && !empty_map;
      push_job.header   = (eff_col == '0);
      push_job.row_cmd  = ROW_CMD | {5'b0, row_addr};
      push_job.col_cmd  = COL_CMD | {1'b0, start_column_ff};
      push_job.pixel    = req_pixel_byte;

      column_count_in = column_count_ff;
      band_count_in   = band_count_ff;
      finished_in     = finished_ff;
      if (accept) begin
         column_count_in = eff_col;
         band_count_in   = eff_band;
         finished_in     = eff_fin;
         if (!eff_fin) begin
            if (empty_map) begin
               finished_in = 1'b1;
            end else if ({1'b0, eff_col} + 8'd1 >= {1'b0, width_pixels_ff}) begin
               column_count_in = '0;
               if ({1'b0, eff_band} + 4'd1 >= bands) begin
                  finished_in   = 1'b1;
                  band_count_in = '0;
               end else begin
                  band_count_in = eff_band + 3'd1;
               end
            end else begin
               column_count_in = eff_col + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         band_count_ff   <= '0;
         finished_ff     <= 1'b1;
      end else begin
         column_count_ff <= column_count_in;
         band_count_ff   <= band_count_in;
         finished_ff     <= finished_in;
      end
   end

endmodule

FILE: rtl/lbsw_queue.sv
// short job queue between front end and serializer
// depends on lbsw_pkg for the job record and depth
`timescale 1ns / 1ps

module lbsw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lbsw_pkg::job_type push_job,
   input  logic              pop,
   output lbsw_pkg::job_type head_job,
   output logic              not_empty,
   output logic              full
);
   import lbsw_pkg::*;

   job_type entry_ff [QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/lbsw_back.sv
// serializer: shifts queued jobs out one bit per beat, MSB first,
// into an output register; depends on lbsw_pkg
`timescale 1ns / 1ps

module lbsw_back (
   input  logic              clock,
   input  logic              reset,
   input  lbsw_pkg::job_type head_job,
   input  logic              queue_not_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_serial_bit,
   output logic              rsp_data_mode,
   output logic              rsp_byte_end,
   output logic              rsp_last
);
   import lbsw_pkg::*;

   logic        busy_ff, busy_in;
   logic [23:0] word_ff, word_in;
   logic [2:0]  bit_cnt_ff, bit_cnt_in;
   logic [1:0]  bytes_left_ff, bytes_left_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic serial_ff, serial_in;
   logic mode_ff, mode_in;
   logic end_ff, end_in;
   logic last_ff, last_in;

   logic out_free;
   logic step;
   logic job_done;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = busy_ff && out_free;
   assign job_done = step && (bit_cnt_ff == 3'd7) && (bytes_left_ff == '0);
   // next job is loaded in the cycle the current one emits its final bit
   assign pop      = queue_not_empty && (!busy_ff || job_done);

   always_comb begin
      busy_in       = busy_ff;
      word_in       = word_ff;
      bit_cnt_in    = bit_cnt_ff;
      bytes_left_in = bytes_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      serial_in     = serial_ff;
      mode_in       = mode_ff;
      end_in        = end_ff;
      last_in       = last_ff;

      if (step) begin
         rsp_valid_in = 1'b1;
         serial_in    = word_ff[23];
         // pixel byte is always the final one of a job
         mode_in      = (bytes_left_ff == '0);
         end_in       = (bit_cnt_ff == 3'd7);
         last_in      = job_done;
         word_in      = {word_ff[22:0], 1'b0};
         bit_cnt_in   = bit_cnt_ff + 3'd1;
         if (bit_cnt_ff == 3'd7) begin
            if (bytes_left_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               bytes_left_in = bytes_left_ff - 2'd1;
            end
         end
      end

      if (pop) begin
         busy_in       = 1'b1;
         bit_cnt_in    = '0;
         if (head_job.header) begin
            word_in       = {head_job.row_cmd, head_job.col_cmd, head_job.pixel};
            bytes_left_in = 2'd2;
         end else begin
            word_in       = {head_job.pixel, 16'h0000};
            bytes_left_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      bit_cnt_ff    <= bit_cnt_in;
      bytes_left_ff <= bytes_left_in;
      serial_ff     <= serial_in;
      mode_ff       <= mode_in;
      end_ff        <= end_in;
      last_ff       <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_serial_bit = serial_ff;
   assign rsp_data_mode  = mode_ff;
   assign rsp_byte_end   = end_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: rtl/lcd_bitmap_serial_writer_top.sv
// top level of the bitmap serial writer: front end, job queue, serializer
// depends on lbsw_pkg, lbsw_front, lbsw_queue, lbsw_back
//
//   channel  direction  signals
//   req      in         req_valid/req_ready, req_first, req_pixel_byte
//   rsp      out        rsp_valid/rsp_ready, rsp_serial_bit, rsp_data_mode,
//                       rsp_byte_end, rsp_last
//   csr      in         csr_valid/csr_ready, csr_index, csr_data
//
// one bit leaves per clock while the serializer is busy and rsp_ready holds;
// a beat sends a pixel byte, led by two command bytes at a band start
// a two-entry job queue lets the front keep accepting while the serializer works
// the first result passes the queue entry, shift word and output register
// reset clears counters, queue, rsp_valid; registers return to full-screen values
`timescale 1ns / 1ps

module lcd_bitmap_serial_writer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_first,
   input  logic [7:0]                      req_pixel_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_serial_bit,
   output logic                            rsp_data_mode,
   output logic                            rsp_byte_end,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lbsw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lbsw_pkg::CSR_DATA_W-1:0]  csr_data
);
   import lbsw_pkg::*;

   logic    push;
   job_type push_job;
   logic    pop;
   job_type head_job;
   logic    q_not_empty;
   logic    q_full;

   lbsw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_first      (req_first),
      .req_pixel_byte (req_pixel_byte),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_full     (q_full),
      .push           (push),
      .push_job       (push_job)
   );

   lbsw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   lbsw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .queue_not_empty (q_not_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_data_mode   (rsp_data_mode),
      .rsp_byte_end    (rsp_byte_end),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for lcd_bitmap_serial_writer_top
// depends on lbsw_pkg and the writer rtl; predicts every serial bit from the bitmap geometry
`timescale 1ns / 1ps

module testbench;
   import lbsw_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct packed {
      logic serial_bit;
      logic data_mode;
      logic byte_end;
      logic last;
   } link_bit_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic          req_first;
   logic [7:0]    req_pixel_byte;
   logic          rsp_valid;
   logic          rsp_ready;
   logic          rsp_serial_bit;
   logic          rsp_data_mode;
   logic          rsp_byte_end;
   logic          rsp_last;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [7:0]    csr_data;

   // geometry as the block should hold it
   logic [6:0] geo_start_column;
   logic [2:0] geo_start_bank;
   logic [6:0] geo_width;
   logic [5:0] geo_height;

   // blit progress
   logic [6:0] blit_column;
   logic [2:0] blit_band;
   logic       blit_done;

   link_bit_type pending_link_bits[$];

   int send_idle_pct;
   int stall_pct;
   int error_count;
   int bits_checked;
   int beats_sent;
   int beats_dropped;
   int last_beat_bits;
   int cycle_count;

   lcd_bitmap_serial_writer_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_first      (req_first),
      .req_pixel_byte (req_pixel_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_data_mode  (rsp_data_mode),
      .rsp_byte_end   (rsp_byte_end),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bits still pending", cycle_count,
                  pending_link_bits.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("%0t ns: %s", $time, msg);
   endtask

   function automatic void push_link_byte(input logic [7:0] value, input logic dmode,
                                          input logic final_byte);
      for (int b = 7; b >= 0; b--) begin
         pending_link_bits.push_back('{value[b], dmode, (b == 0), (final_byte && b == 0)});
      end
   endfunction

   // returns the number of serial bits the beat produces
   function automatic int predict_blit(input logic first, input logic [7:0] pix);
      int         bands;
      logic [2:0] bank_addr;
      int         made;
      made = 0;
      if (first) begin
         blit_column = '0;
         blit_band   = '0;
         blit_done   = 1'b0;
      end
      if (blit_done)
         return 0;
      if (geo_width == 0 || geo_height == 0) begin
         blit_done = 1'b1;
         return 0;
      end
      bands = (int'(geo_height) + 7) / 8;
      if (blit_column == 0) begin
         bank_addr = geo_start_bank + blit_band;
         push_link_byte(ROW_CMD | {5'd0, bank_addr}, 1'b0, 1'b0);
         push_link_byte(COL_CMD | {1'b0, geo_start_column}, 1'b0, 1'b0);
         made += 16;
      end
      push_link_byte(pix, 1'b1, 1'b1);
      made += 8;
      if (int'(blit_column) + 1 >= int'(geo_width)) begin
         blit_column = '0;
         if (int'(blit_band) + 1 >= bands) begin
            blit_done = 1'b1;
            blit_band = '0;
         end else begin
            blit_band = blit_band + 3'd1;
         end
      end else begin
         blit_column = blit_column + 7'd1;
      end
      return made;
   endfunction

   always @(posedge clock) begin
      link_bit_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         bits_checked++;
         if (pending_link_bits.size() == 0) begin
            report_error($sformatf("unexpected bit: serial %0b mode %0b end %0b last %0b",
                                   rsp_serial_bit, rsp_data_mode, rsp_byte_end, rsp_last));
         end else begin
            want = pending_link_bits.pop_front();
            if (rsp_serial_bit !== want.serial_bit)
               report_error($sformatf("serial_bit %0b, expected %0b", rsp_serial_bit,
                                      want.serial_bit));
            if (rsp_data_mode !== want.data_mode)
               report_error($sformatf("data_mode %0b, expected %0b", rsp_data_mode,
                                      want.data_mode));
            if (rsp_byte_end !== want.byte_end)
               report_error($sformatf("byte_end %0b, expected %0b", rsp_byte_end,
                                      want.byte_end));
            if (rsp_last !== want.last)
               report_error($sformatf("last %0b, expected %0b", rsp_last, want.last));
         end
      end
   end

   // valid is only lowered when an idle gap follows, so a held valid never glitches
   task automatic send_beat(input logic first, input logic [7:0] pix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_first      <= first;
      req_pixel_byte <= pix;
      do @(posedge clock); while (!req_ready);
      last_beat_bits = predict_blit(first, pix);
      beats_sent++;
      if (last_beat_bits == 0)
         beats_dropped++;
   endtask

   task automatic drain_link();
      req_valid <= 1'b0;
      while (pending_link_bits.size() != 0) @(posedge clock);
      // dropped beats leave no trace, give the front end time to settle
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // negative value leaves that register alone
   task automatic set_geometry(input int col, input int bank, input int wid, input int hgt);
      int         vals[4];
      logic [7:0] wdata;
      vals = '{col, bank, wid, hgt};
      for (int i = 0; i < 4; i++) begin
         if (vals[i] >= 0) begin
            wdata = vals[i][7:0];
            csr_valid <= 1'b1;
            csr_index <= csr_index_type'(i);
            csr_data  <= wdata;
            do @(posedge clock); while (!csr_ready);
            case (csr_index_type'(i))
               CSR_START_COLUMN:  geo_start_column = wdata[6:0];
               CSR_START_BANK:    geo_start_bank   = wdata[2:0];
               CSR_WIDTH_PIXELS:  geo_width        = wdata[6:0];
               CSR_HEIGHT_PIXELS: geo_height       = wdata[5:0];
               default: ;
            endcase
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_idle();
      // nothing has started yet, so plain beats are dropped
      send_beat(1'b0, 8'h5A);
      send_beat(1'b0, 8'hA5);
      send_beat(1'b0, 8'hFF);
      // full-screen defaults after reset
      send_beat(1'b1, 8'h3C);
      send_beat(1'b0, 8'hC3);
      drain_link();
   endtask

   task automatic test_pixel_extremes();
      set_geometry(0, 0, 4, 8);
      send_beat(1'b1, 8'h00);
      send_beat(1'b0, 8'hFF);
      send_beat(1'b0, 8'h80);
      send_beat(1'b0, 8'h01);
      // past the last band
      send_beat(1'b0, 8'h7E);
      drain_link();
   endtask

   task automatic test_bank_wrap_far_column();
      set_geometry(127, 7, 1, 16);
      send_beat(1'b1, 8'h96);
      send_beat(1'b0, 8'h69);
      drain_link();
   endtask

   task automatic test_empty_bitmap();
      set_geometry(-1, -1, 0, -1);
      send_beat(1'b1, 8'h11);
      send_beat(1'b0, 8'h22);
      drain_link();
      set_geometry(-1, -1, 2, 0);
      send_beat(1'b1, 8'h33);
      drain_link();
      // eight bands from bank 3, the bank address wraps on the way
      set_geometry(83, 3, 1, 63);
      for (int i = 0; i < 8; i++)
         send_beat(i == 0, 8'(8'h10 + i));
      send_beat(1'b0, 8'hEE);
      drain_link();
   endtask

   task automatic random_geometry(input bit write_all);
      int col, bank, wid, hgt, r;
      col = -1; bank = -1; wid = -1; hgt = -1;
      if (write_all || $urandom_range(99) < 60) begin
         r = $urandom_range(99);
         col = (r < 15) ? 0 : (r < 30) ? 127 : (r < 40) ? 83 : $urandom_range(255);
      end
      if (write_all || $urandom_range(99) < 60)
         bank = ($urandom_range(3) == 0) ? 7 : $urandom_range(255);
      if (write_all || $urandom_range(99) < 60) begin
         r = $urandom_range(99);
         if (r < 5)       wid = 0;
         else if (r < 50) wid = $urandom_range(1, 4);
         else if (r < 80) wid = $urandom_range(5, 12);
         else if (r < 88) wid = 84;
         else if (r < 93) wid = 127;
         else             wid = $urandom_range(1, 20) | ($urandom_range(1) << 7);
      end
      if (write_all || $urandom_range(99) < 60) begin
         r = $urandom_range(99);
         if (r < 4)       hgt = 0;
         else if (r < 50) hgt = $urandom_range(1, 16);
         else if (r < 80) hgt = $urandom_range(17, 32);
         else if (r < 88) hgt = 48;
         else if (r < 94) hgt = 63;
         else             hgt = $urandom_range(255);
      end
      set_geometry(col, bank, wid, hgt);
   endtask

   // mostly whole bitmaps with random pixels, some noise and cut-short bitmaps
   task automatic blit_segment(input int budget);
      int made, tries, kind, len, full;
      made = 0;
      tries = 0;
      while (made < budget && tries < 3 * budget) begin
         kind = $urandom_range(99);
         full = int'(geo_width) * ((int'(geo_height) + 7) / 8);
         if (kind < 70) begin
            len = full;
            if (len > budget - made + 4) len = budget - made + 4;
            if (len < 1) len = 1;
            for (int i = 0; i < len; i++) begin
               send_beat(i == 0, 8'($urandom_range(255)));
               tries++;
               if (last_beat_bits != 0) made++;
            end
            if ($urandom_range(99) < 30)
               send_beat(1'b0, 8'($urandom_range(255)));
         end else if (kind < 85) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               send_beat($urandom_range(3) == 0, 8'($urandom_range(255)));
               tries++;
               if (last_beat_bits != 0) made++;
            end
         end else begin
            len = (full > 1) ? $urandom_range(1, full - 1) : 1;
            if (len > 8) len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               send_beat(i == 0, 8'($urandom_range(255)));
               tries++;
               if (last_beat_bits != 0) made++;
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      int idle_mode[4];
      int stall_mode[4];
      idle_mode  = '{0, 86, 0, 33};
      stall_mode = '{0, 0, 86, 33};
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 4; s++) begin
            drain_link();
            // geometry changes land while a bitmap may be half done
            random_geometry(p == 0 && s == 0);
            send_idle_pct = idle_mode[p];
            stall_pct     = stall_mode[p];
            blit_segment(20);
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
      drain_link();
   endtask

   initial begin
      error_count   = 0;
      bits_checked  = 0;
      beats_sent    = 0;
      beats_dropped = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      geo_start_column = 7'd0;
      geo_start_bank   = 3'd0;
      geo_width        = 7'(DISPLAY_COLUMNS);
      geo_height       = 6'(8 * DISPLAY_BANKS);
      blit_column = '0;
      blit_band   = '0;
      blit_done   = 1'b1;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_first      <= 1'b0;
      req_pixel_byte <= 8'h00;
      rsp_ready      <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= CSR_START_COLUMN;
      csr_data       <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_idle();
      test_pixel_extremes();
      test_bank_wrap_far_column();
      test_empty_bitmap();
      test_random_traffic();

      $display("sent %0d pixel beats (%0d dropped), checked %0d serial bits",
               beats_sent, beats_dropped, bits_checked);
      $display("geometry extremes, bank wrap, empty bitmaps and four idle/stall mixes run");
      if (error_count == 0 && pending_link_bits.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d bits never seen", error_count,
                  pending_link_bits.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/lbsw_pkg.sv
rtl/lbsw_front.sv
rtl/lbsw_queue.sv
rtl/lbsw_back.sv
rtl/lcd_bitmap_serial_writer_top.sv
tb/testbench.sv
